@@ hw/rtl/ppc_pkg.sv @@
// Shared constants, types and tables for the pursuit proportional controller.
package ppc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_TAB_LEN    = 24;
    localparam int SQRT_STEPS        = 17;

    localparam int POS_W  = 16;
    localparam int DIFF_W = 17;
    localparam int HEAD_W = 16;
    localparam int XY_W   = 36;
    localparam int XY_SHIFT = 14;
    localparam int ANG_W  = 20;
    localparam int SQ_W   = 35;
    localparam int DIST_W = 17;
    localparam int LIN_W  = 24;
    localparam int ANGC_W = 20;
    localparam int GAIN_W = 12;
    localparam int STOFF_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 64;

    localparam logic [GAIN_W-1:0]  GAIN_LINEAR_RST  = 12'd2304;
    localparam logic [GAIN_W-1:0]  GAIN_ANGULAR_RST = 12'd1280;
    localparam logic [STOFF_W-1:0] STANDOFF_RST     = 15'd1024;

    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 20'sd102944;
    localparam logic signed [17:0] Q13_PI     = 18'sd25736;
    localparam logic signed [17:0] Q13_TWO_PI = 18'sd51472;

    // register indexes of the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_LINEAR  = 2'd0,
        CFG_GAIN_ANGULAR = 2'd1,
        CFG_STANDOFF     = 2'd2
    } t_cfg_index;

    // payload carried along the cell chain
    typedef struct packed {
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [ANG_W-1:0]  z;
        logic [SQ_W-1:0]          rem;
        logic [SQ_W-1:0]          root;
        logic                     coincident;
        logic signed [HEAD_W-1:0] heading;
    } t_cell_data;

    // atan(2^-i) in units of 2^-16 rad
    function automatic logic signed [ANG_W-1:0] atan_at(input int i);
        case (i)
            0:       return 20'sd51472;
            1:       return 20'sd30385;
            2:       return 20'sd16055;
            3:       return 20'sd8150;
            4:       return 20'sd4091;
            5:       return 20'sd2047;
            6:       return 20'sd1024;
            7:       return 20'sd512;
            8:       return 20'sd256;
            9:       return 20'sd128;
            10:      return 20'sd64;
            11:      return 20'sd32;
            12:      return 20'sd16;
            13:      return 20'sd8;
            14:      return 20'sd4;
            15:      return 20'sd2;
            16:      return 20'sd1;
            default: return 20'sd0;
        endcase
    endfunction

endpackage

@@ hw/rtl/ppc_front.sv @@
// Front end: position differences, squared distance and CORDIC quadrant fold.
module ppc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [ppc_pkg::POS_W-1:0]  i_leader_x,
    input  logic signed [ppc_pkg::POS_W-1:0]  i_leader_y,
    input  logic signed [ppc_pkg::POS_W-1:0]  i_follower_x,
    input  logic signed [ppc_pkg::POS_W-1:0]  i_follower_y,
    input  logic signed [ppc_pkg::HEAD_W-1:0] i_follower_heading,
    output logic                              o_valid,
    input  logic                              i_ready,
    output ppc_pkg::t_cell_data               o_data
);

    logic                               r1_valid;
    logic signed [ppc_pkg::DIFF_W-1:0]  r1_dx, r1_dy;
    logic signed [ppc_pkg::HEAD_W-1:0]  r1_head;
    logic                               r2_valid;
    ppc_pkg::t_cell_data                r2_data;

    logic                               ready1, ready2;
    logic signed [ppc_pkg::DIFF_W-1:0]  n_dx, n_dy;
    logic signed [2*ppc_pkg::DIFF_W-1:0] dx2, dy2;
    logic signed [ppc_pkg::XY_W-1:0]    x0, y0;
    ppc_pkg::t_cell_data                n_data;

    assign ready2  = !r2_valid || i_ready;
    assign ready1  = !r1_valid || ready2;
    assign o_ready = ready1;
    assign o_valid = r2_valid;
    assign o_data  = r2_data;

    assign n_dx = ppc_pkg::DIFF_W'(i_leader_x) - ppc_pkg::DIFF_W'(i_follower_x);
    assign n_dy = ppc_pkg::DIFF_W'(i_leader_y) - ppc_pkg::DIFF_W'(i_follower_y);

    assign dx2 = r1_dx * r1_dx;
    assign dy2 = r1_dy * r1_dy;
    assign x0  = ppc_pkg::XY_W'(r1_dx) <<< ppc_pkg::XY_SHIFT;
    assign y0  = ppc_pkg::XY_W'(r1_dy) <<< ppc_pkg::XY_SHIFT;

    always_comb begin
        n_data.rem        = ppc_pkg::SQ_W'(unsigned'(dx2)) + ppc_pkg::SQ_W'(unsigned'(dy2));
        n_data.root       = '0;
        n_data.coincident = (r1_dx == '0) && (r1_dy == '0);
        n_data.heading    = r1_head;
        n_data.x          = x0;
        n_data.y          = y0;
        n_data.z          = '0;
        // left half plane: rotate by a quarter turn first
        if (r1_dx[ppc_pkg::DIFF_W-1]) begin
            if (!r1_dy[ppc_pkg::DIFF_W-1]) begin
                n_data.x = y0;
                n_data.y = -x0;
                n_data.z = ppc_pkg::ANG_HALF_PI;
            end else begin
                n_data.x = -y0;
                n_data.y = x0;
                n_data.z = -ppc_pkg::ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (ready1) r1_valid <= i_valid;
            if (ready2) r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r1_dx   <= n_dx;
            r1_dy   <= n_dy;
            r1_head <= i_follower_heading;
        end
        if (ready2 && r1_valid) r2_data <= n_data;
    end

endmodule

@@ hw/rtl/ppc_cell.sv @@
// One chain cell: a CORDIC vectoring iteration and/or a square root digit step, each enabled by a parameter.
module ppc_cell #(
    parameter int IDX       = 0,
    parameter bit DO_CORDIC = 1'b1,
    parameter bit DO_SQRT   = 1'b1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ppc_pkg::t_cell_data i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output ppc_pkg::t_cell_data o_data
);

    localparam int SQ_SH = DO_SQRT ? 2 * (ppc_pkg::SQRT_STEPS - 1 - IDX) : 0;
    localparam logic [ppc_pkg::SQ_W-1:0] SQ_BIT = ppc_pkg::SQ_W'(1) << SQ_SH;
    localparam logic signed [ppc_pkg::ANG_W-1:0] ATAN = ppc_pkg::atan_at(IDX);

    logic                            r_valid;
    ppc_pkg::t_cell_data             r_data;
    ppc_pkg::t_cell_data             n_data;
    logic signed [ppc_pkg::XY_W-1:0] xs, ys;
    logic [ppc_pkg::SQ_W-1:0]        trial;
    logic                            ready;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign xs    = i_data.x >>> IDX;
    assign ys    = i_data.y >>> IDX;
    assign trial = i_data.root + SQ_BIT;

    always_comb begin
        n_data = i_data;
        if (DO_CORDIC) begin
            if (!i_data.y[ppc_pkg::XY_W-1]) begin
                n_data.x = i_data.x + ys;
                n_data.y = i_data.y - xs;
                n_data.z = i_data.z + ATAN;
            end else begin
                n_data.x = i_data.x - ys;
                n_data.y = i_data.y + xs;
                n_data.z = i_data.z - ATAN;
            end
        end
        if (DO_SQRT) begin
            if (i_data.rem >= trial) begin
                n_data.rem  = i_data.rem - trial;
                n_data.root = (i_data.root >> 1) + SQ_BIT;
            end else begin
                n_data.root = i_data.root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) r_data <= n_data;
    end

endmodule

@@ hw/rtl/ppc_back.sv @@
// Back end: bearing rounding, angle wrap, gain products, saturation, output register.
module ppc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  ppc_pkg::t_cell_data                i_data,
    input  logic [ppc_pkg::GAIN_W-1:0]         i_gain_linear,
    input  logic [ppc_pkg::GAIN_W-1:0]         i_gain_angular,
    input  logic [ppc_pkg::STOFF_W-1:0]        i_standoff,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ppc_pkg::DIST_W-1:0]         o_distance,
    output logic signed [ppc_pkg::LIN_W-1:0]   o_linear_command,
    output logic signed [ppc_pkg::ANGC_W-1:0]  o_angular_command
);

    localparam logic signed [ppc_pkg::ANG_W-1:0] Z_HALF = 20'sd4;
    localparam logic signed [30:0] LIN_RND = 31'sd128;
    localparam logic signed [28:0] ANG_RND = 29'sd128;
    localparam logic signed [30:0] LIN_MAX = 31'sd8388607;
    localparam logic signed [30:0] LIN_MIN = -31'sd8388608;
    localparam logic signed [28:0] ANG_MAX = 29'sd524287;
    localparam logic signed [28:0] ANG_MIN = -29'sd524288;

    logic                              r1_valid, r2_valid, r3_valid;
    logic [ppc_pkg::DIST_W-1:0]        r1_dist, r2_dist, r3_dist;
    logic signed [15:0]                r1_err;
    logic signed [17:0]                r1_ldiff;
    logic signed [30:0]                r2_lprod;
    logic signed [28:0]                r2_aprod;
    logic signed [ppc_pkg::LIN_W-1:0]  r3_lin;
    logic signed [ppc_pkg::ANGC_W-1:0] r3_ang;

    logic                              ready1, ready2, ready3;
    logic signed [ppc_pkg::ANG_W-1:0]  zr, bearing;
    logic signed [17:0]                err, err_w, n_ldiff;
    logic [ppc_pkg::DIST_W-1:0]        n_dist;
    logic signed [30:0]                lprod, lr;
    logic signed [28:0]                aprod, ar;
    logic signed [ppc_pkg::LIN_W-1:0]  n_lin;
    logic signed [ppc_pkg::ANGC_W-1:0] n_ang;

    assign ready3  = !r3_valid || i_ready;
    assign ready2  = !r2_valid || ready3;
    assign ready1  = !r1_valid || ready2;
    assign o_ready = ready1;
    assign o_valid = r3_valid;
    assign o_distance        = r3_dist;
    assign o_linear_command  = r3_lin;
    assign o_angular_command = r3_ang;

    // stage 1: round bearing to Q3.13, wrap the error into (-pi, pi]
    assign zr      = (i_data.z + Z_HALF) >>> 3;
    assign bearing = i_data.coincident ? '0 : zr;
    assign err     = 18'(bearing) - 18'(i_data.heading);
    assign n_dist  = i_data.root[ppc_pkg::DIST_W-1:0];
    assign n_ldiff = signed'({1'b0, n_dist}) - signed'({3'b0, i_standoff});

    always_comb begin
        priority if (err > ppc_pkg::Q13_PI) err_w = err - ppc_pkg::Q13_TWO_PI;
        else if (err <= -ppc_pkg::Q13_PI)   err_w = err + ppc_pkg::Q13_TWO_PI;
        else                                err_w = err;
    end

    // stage 2: gain products
    assign lprod = r1_ldiff * signed'({1'b0, i_gain_linear});
    assign aprod = r1_err * signed'({1'b0, i_gain_angular});

    // stage 3: round half up, saturate
    assign lr = (r2_lprod + LIN_RND) >>> 8;
    assign ar = (r2_aprod + ANG_RND) >>> 8;

    always_comb begin
        priority if (lr > LIN_MAX) n_lin = LIN_MAX[ppc_pkg::LIN_W-1:0];
        else if (lr < LIN_MIN)     n_lin = LIN_MIN[ppc_pkg::LIN_W-1:0];
        else                       n_lin = lr[ppc_pkg::LIN_W-1:0];
        priority if (ar > ANG_MAX) n_ang = ANG_MAX[ppc_pkg::ANGC_W-1:0];
        else if (ar < ANG_MIN)     n_ang = ANG_MIN[ppc_pkg::ANGC_W-1:0];
        else                       n_ang = ar[ppc_pkg::ANGC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (ready1) r1_valid <= i_valid;
            if (ready2) r2_valid <= r1_valid;
            if (ready3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r1_dist  <= n_dist;
            r1_err   <= err_w[15:0];
            r1_ldiff <= n_ldiff;
        end
        if (ready2 && r1_valid) begin
            r2_dist  <= r1_dist;
            r2_lprod <= lprod;
            r2_aprod <= aprod;
        end
        if (ready3 && r2_valid) begin
            r3_dist <= r2_dist;
            r3_lin  <= n_lin;
            r3_ang  <= n_ang;
        end
    end

endmodule

@@ hw/rtl/pursuit_proportional_controller.sv @@
// Top level of the pursuit proportional controller: config registers and the pipeline.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+--------------------------------------------
//   s_*     | in  | s_tvalid/s_tready  | leader x/y, follower x/y, follower heading
//   m_*     | out | m_tvalid/m_tready  | distance, linear command, angular command
//   i_cfg_* | in  | i_cfg_we           | gain_linear, gain_angular, standoff_distance
//
// One transfer in per cycle, one result out per cycle, as long as m_tready stays high.
// Stages: two front stages, one chain cell per CORDIC iteration / square root digit
// with CHAIN_LEN = max(CORDIC_STAGES, 17) cells, and three back stages.
// Synchronous active-low reset clears the valid bits and loads the default gains and standoff.
// Every stage holds its own valid; a stall at m_tready fills bubbles first, so
// s_tready drops only once the whole pipeline holds data.
module pursuit_proportional_controller #(
    parameter int CORDIC_STAGES = ppc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tdata: leader_x[15:0], leader_y[31:16], follower_x[47:32],
    //        follower_y[63:48], follower_heading[79:64]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ppc_pkg::IN_DATA_W-1:0]       s_tdata,
    // tdata: distance[16:0], linear_command[40:17], angular_command[60:41], zero[63:61]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ppc_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CHAIN_LEN = (CORDIC_STAGES > ppc_pkg::SQRT_STEPS) ?
                               CORDIC_STAGES : ppc_pkg::SQRT_STEPS;

    // configuration registers
    logic [ppc_pkg::GAIN_W-1:0]  r_gain_linear;
    logic [ppc_pkg::GAIN_W-1:0]  r_gain_angular;
    logic [ppc_pkg::STOFF_W-1:0] r_standoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_linear  <= ppc_pkg::GAIN_LINEAR_RST;
            r_gain_angular <= ppc_pkg::GAIN_ANGULAR_RST;
            r_standoff     <= ppc_pkg::STANDOFF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppc_pkg::CFG_GAIN_LINEAR:  r_gain_linear  <= i_cfg_data[ppc_pkg::GAIN_W-1:0];
                ppc_pkg::CFG_GAIN_ANGULAR: r_gain_angular <= i_cfg_data[ppc_pkg::GAIN_W-1:0];
                ppc_pkg::CFG_STANDOFF:     r_standoff     <= i_cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // chain links: index 0 from the front end, CHAIN_LEN into the back end
    logic                c_valid [0:CHAIN_LEN];
    logic                c_ready [0:CHAIN_LEN];
    ppc_pkg::t_cell_data c_data  [0:CHAIN_LEN];

    logic [ppc_pkg::DIST_W-1:0]         distance;
    logic signed [ppc_pkg::LIN_W-1:0]   linear_command;
    logic signed [ppc_pkg::ANGC_W-1:0]  angular_command;

    ppc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (s_tvalid),
        .o_ready            (s_tready),
        .i_leader_x         (s_tdata[15:0]),
        .i_leader_y         (s_tdata[31:16]),
        .i_follower_x       (s_tdata[47:32]),
        .i_follower_y       (s_tdata[63:48]),
        .i_follower_heading (s_tdata[79:64]),
        .o_valid            (c_valid[0]),
        .i_ready            (c_ready[0]),
        .o_data             (c_data[0])
    );

    // each cell does CORDIC iteration k and square root digit k where those exist
    for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
        ppc_cell #(
            .IDX       (k),
            .DO_CORDIC ((k < CORDIC_STAGES) && (k < ppc_pkg::CORDIC_TAB_LEN)),
            .DO_SQRT   (k < ppc_pkg::SQRT_STEPS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_data  (c_data[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_data  (c_data[k+1])
        );
    end

    ppc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (c_valid[CHAIN_LEN]),
        .o_ready           (c_ready[CHAIN_LEN]),
        .i_data            (c_data[CHAIN_LEN]),
        .i_gain_linear     (r_gain_linear),
        .i_gain_angular    (r_gain_angular),
        .i_standoff        (r_standoff),
        .o_valid           (m_tvalid),
        .i_ready           (m_tready),
        .o_distance        (distance),
        .o_linear_command  (linear_command),
        .o_angular_command (angular_command)
    );

    assign m_tdata = {3'b000, angular_command, linear_command, distance};

endmodule

@@ hw/rtl/ppc_checker.sv @@
// Port-level checker for the pursuit proportional controller, bound to the top level.
module ppc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ppc_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic signed [ppc_pkg::ANGC_W-1:0] ang;
    assign ang = m_tdata[60:41];

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    // an empty output means the chain cannot be full
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // distance never exceeds sqrt(2) * 65535 in Q7.10
    a_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[16:0] <= 17'd92681) && (m_tdata[63:61] == 3'b000))
        else $error("distance out of range");

    // wrapped error times the largest gain bounds the turn command
    a_ang: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (ang <= 20'sd411675) && (ang >= -20'sd411675))
        else $error("angular command beyond wrapped range");

endmodule

bind pursuit_proportional_controller ppc_checker u_ppc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
